// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// ASSERT_CLKD: checked at the clock edge, skipped while reset is asserted.
// ASSERT_RAW: checked at every clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLKD(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

`define ASSERT_RAW(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ----- rtl/kcs_pkg.sv -----
// ----------------------------------------------------------------------------
// kcs_pkg
// Types and constants of the keyword capability scanner: item formats,
// the marker table and the context estimate constants.
// ----------------------------------------------------------------------------
package kcs_pkg;

    // Window geometry: newest byte plus nine history bytes
    localparam int unsigned WIN_BYTES    = 10;
    localparam int unsigned HIST_DEPTH   = 9;
    localparam int unsigned MARKER_COUNT = 15;
    localparam int unsigned GROUP_COUNT  = 3;
    localparam int unsigned CTX_W        = 19;

    // Context estimate constants
    localparam int unsigned EST_LIMIT = 4096;
    localparam int unsigned CTX_BIAS  = 1024;

    // Case folding bounds
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    // Marker group codes (bit positions in the hit flags)
    localparam logic [1:0] GRP_IMAGE = 2'd0;
    localparam logic [1:0] GRP_PDF   = 2'd1;
    localparam logic [1:0] GRP_AUDIO = 2'd2;

    typedef logic [8*WIN_BYTES-1:0] kcs_win_t;
    typedef logic [GROUP_COUNT-1:0] kcs_hits_t;
    typedef logic [3:0]             kcs_len_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
        logic       tools_allowed;
    } kcs_in_t;

    typedef struct packed {
        logic             need_tools;
        logic             need_vision;
        logic             need_pdf;
        logic             need_audio;
        logic [CTX_W-1:0] ctx_tokens;
    } kcs_out_t;

    // Marker text, right aligned: the final character sits in bits [7:0]
    localparam kcs_win_t MARKER_TEXT [MARKER_COUNT] = '{
        ".png", ".jpg", ".jpeg", ".webp", ".gif", "screenshot", {"image", "_url"},
        ".pdf", " pdf ",
        ".mp3", ".wav", ".m4a", ".ogg", ".flac", ".aac"
    };

    localparam kcs_len_t MARKER_LEN [MARKER_COUNT] = '{
        4'd4, 4'd4, 4'd5, 4'd5, 4'd4, 4'd10, 4'd9,
        4'd4, 4'd5,
        4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd4
    };

    localparam logic [1:0] MARKER_GROUP [MARKER_COUNT] = '{
        GRP_IMAGE, GRP_IMAGE, GRP_IMAGE, GRP_IMAGE, GRP_IMAGE, GRP_IMAGE, GRP_IMAGE,
        GRP_PDF, GRP_PDF,
        GRP_AUDIO, GRP_AUDIO, GRP_AUDIO, GRP_AUDIO, GRP_AUDIO, GRP_AUDIO
    };

    // Byte mask covering the low len bytes of the window
    function automatic kcs_win_t marker_mask(input kcs_len_t len);
        kcs_win_t m;
        m = '0;
        for (int k = 0; k < WIN_BYTES; k++) begin
            if (k < int'(len)) begin
                m[8*k +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // Lowercase A-Z, pass everything else unchanged
    function automatic logic [7:0] fold_case(input logic [7:0] b);
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
            return b + CASE_OFFSET;
        end
        return b;
    endfunction

endpackage

// ----- rtl/keyword_capability_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// keyword_capability_scanner_unit
// Streams prompt bytes and flags vision, pdf and audio markers, plus a
// minimum context estimate, once per prompt.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready/s_data carries one prompt byte per item,
//   with last_byte marking the final item of a prompt and tools_allowed
//   sampled on that item. A zero byte ends the text; later bytes are ignored.
//   Result channel m_valid/m_ready/m_data carries one item per prompt, built
//   from the last input item.
//   Timing: one input item per cycle while no last item waits for the result
//   slot. An item is captured in the input register and scanned there against
//   the 15 markers over a ten-byte window; the answer is registered in the
//   result register when the last item leaves the input register.
//   Stall: while a result waits on m_ready, ordinary bytes keep flowing; only
//   a following last item waits in the input register, so s_ready drops only
//   then.
//   Reset (aresetn low, synchronous): empties both registers, clears the
//   history window, hit flags, byte count and end-of-text flag. The same
//   state is cleared after each prompt's result is formed.
// ----------------------------------------------------------------------------
module keyword_capability_scanner_unit #(
    parameter int unsigned MAX_PROMPT_BYTES = 1048576
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  kcs_pkg::kcs_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output kcs_pkg::kcs_out_t m_data
);
    import kcs_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_PROMPT_BYTES + 1);
    localparam int unsigned SUM_W = ((CNT_W > CTX_W) ? CNT_W : CTX_W) + 1;

    // Input register
    logic     in_valid_reg;
    kcs_in_t  in_data_reg;

    // Scan state
    logic [7:0]       recent_reg [HIST_DEPTH];
    logic [7:0]       recent_next [HIST_DEPTH];
    kcs_hits_t        hits_reg, hits_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ended_reg, ended_next;

    // Result register
    logic     out_valid_reg;
    kcs_out_t out_data_reg, out_data_next;

    logic             out_free;
    logic             fire;
    logic [7:0]       folded;
    kcs_win_t         window;
    kcs_hits_t        match_hits;
    logic [CNT_W-1:0] count_upd;
    kcs_hits_t        hits_upd;
    logic [SUM_W-1:0] est_wide;
    logic [SUM_W-1:0] ctx_wide;

    // Advance the held item unless it is a last item and the result slot is busy
    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && (!in_data_reg.last_byte || out_free);
    assign s_ready  = !in_valid_reg || fire;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Capture the incoming item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Build the window and compare every marker against its newest end
    always_comb begin
        folded        = fold_case(in_data_reg.text_byte);
        window[7:0]   = folded;
        for (int i = 0; i < HIST_DEPTH; i++) begin
            window[8*(i+1) +: 8] = recent_reg[i];
        end
        match_hits = '0;
        for (int m = 0; m < MARKER_COUNT; m++) begin
            if ((window & marker_mask(MARKER_LEN[m])) == MARKER_TEXT[m]) begin
                match_hits[MARKER_GROUP[m]] = 1'b1;
            end
        end
    end

    // Update scan state and form the result
    always_comb begin
        recent_next = recent_reg;
        hits_upd    = hits_reg;
        count_upd   = count_reg;
        ended_next  = ended_reg;

        if (!ended_reg) begin
            if (in_data_reg.text_byte == CHAR_NUL) begin
                ended_next = 1'b1;
            end else begin
                hits_upd = hits_reg | match_hits;
                for (int i = HIST_DEPTH - 1; i > 0; i--) begin
                    recent_next[i] = recent_reg[i-1];
                end
                recent_next[0] = folded;
                if (count_reg < CNT_W'(MAX_PROMPT_BYTES)) begin
                    count_upd = count_reg + CNT_W'(1);
                end
            end
        end

        // Context estimate: count/4 + 1, biased when above the limit, else zero
        est_wide = SUM_W'(count_upd >> 2) + SUM_W'(1);
        if (est_wide > SUM_W'(EST_LIMIT)) begin
            ctx_wide = est_wide + SUM_W'(CTX_BIAS);
        end else begin
            ctx_wide = '0;
        end

        out_data_next.need_tools  = in_data_reg.tools_allowed;
        out_data_next.need_vision = hits_upd[GRP_IMAGE];
        out_data_next.need_pdf    = hits_upd[GRP_PDF];
        out_data_next.need_audio  = hits_upd[GRP_AUDIO];
        out_data_next.ctx_tokens  = ctx_wide[CTX_W-1:0];

        hits_next  = hits_upd;
        count_next = count_upd;

        // Drop all prompt state once the result is formed
        if (in_data_reg.last_byte) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                recent_next[i] = 8'h00;
            end
            hits_next  = '0;
            count_next = '0;
            ended_next = 1'b0;
        end
    end

    // Hold scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                recent_reg[i] <= 8'h00;
            end
            hits_reg  <= '0;
            count_reg <= '0;
            ended_reg <= 1'b0;
        end else if (fire) begin
            recent_reg <= recent_next;
            hits_reg   <= hits_next;
            count_reg  <= count_next;
            ended_reg  <= ended_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && in_data_reg.last_byte) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (fire && in_data_reg.last_byte) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ----- rtl/kcs_checker.sv -----
// ----------------------------------------------------------------------------
// kcs_checker
// Port-level checks of the keyword capability scanner, bound to the scanner module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kcs_checker #(
    parameter int unsigned MAX_PROMPT_BYTES = 1048576
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input kcs_pkg::kcs_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input kcs_pkg::kcs_out_t m_data
);
    import kcs_pkg::*;

    localparam longint unsigned CTX_MAX  = longint'(MAX_PROMPT_BYTES / 4) + 1 + CTX_BIAS;
    localparam logic            NO_WRAP  = (CTX_MAX < (longint'(1) << CTX_W));
    localparam logic [CTX_W-1:0] CTX_MIN = CTX_W'(EST_LIMIT + 1 + CTX_BIAS);
    localparam logic [CTX_W-1:0] CTX_TOP = CTX_W'(CTX_MAX);

    logic ctx_ok;
    assign ctx_ok = !NO_WRAP || m_data.ctx_tokens == '0
                    || (m_data.ctx_tokens >= CTX_MIN && m_data.ctx_tokens <= CTX_TOP);

    // A pending result that stalls keeps its value
    `ASSERT_CLKD(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // An offered input item waits unchanged until it is taken
    `ASSERT_CLKD(a_in_hold, aclk, aresetn, s_valid && !s_ready |=> s_valid && $stable(s_data))

    // Reset empties the result register
    `ASSERT_RAW(a_reset_empty, aclk, !aresetn |=> !m_valid)

    // With the result slot free, input is never back-pressured
    `ASSERT_CLKD(a_ready_free, aclk, aresetn, (!m_valid || m_ready) |-> s_ready)

    // Context estimate is zero or lies within the biased range
    `ASSERT_CLKD(a_ctx_range, aclk, aresetn, m_valid |-> ctx_ok)

endmodule

bind keyword_capability_scanner_unit kcs_checker #(
    .MAX_PROMPT_BYTES(MAX_PROMPT_BYTES)
) u_kcs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- tb/sv/tb_keyword_capability_scanner_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyword_capability_scanner_unit
// Streams prompt bytes into the scanner and checks every capability result
// against a local model of the marker scan, the byte count and the context
// estimate. A short table of hand-picked prompts comes first. Random prompts
// follow, built from markers, near misses, filler and ignored tails, under
// three idling mixes and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_keyword_capability_scanner_unit;
    import kcs_pkg::*;

    // Byte-count ceiling handed to the block and to the model
    localparam int unsigned TB_MAX_BYTES = 65536;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned PHASE_ITEMS  = 340;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       tools;
        logic       typed;
        kcs_out_t   want;
    } probe_row_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    kcs_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    kcs_out_t m_data;

    // Scan model state
    logic [7:0]  hist_bytes [9];
    logic [2:0]  group_hits;
    int unsigned text_len;
    bit          text_done;

    kcs_out_t    expected_caps_q [$];
    logic [7:0]  prompt_q [$];
    int unsigned mismatch_count;
    int unsigned result_count;
    int unsigned scan_items;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_request;

    string marker_text [MARKER_COUNT] = '{
        ".png", ".jpg", ".jpeg", ".webp", ".gif", "screenshot", string'({"image", "_url"}),
        ".pdf", " pdf ",
        ".mp3", ".wav", ".m4a", ".ogg", ".flac", ".aac"
    };
    logic [1:0] marker_grp [MARKER_COUNT] = '{
        GRP_IMAGE, GRP_IMAGE, GRP_IMAGE, GRP_IMAGE, GRP_IMAGE, GRP_IMAGE, GRP_IMAGE,
        GRP_PDF, GRP_PDF,
        GRP_AUDIO, GRP_AUDIO, GRP_AUDIO, GRP_AUDIO, GRP_AUDIO, GRP_AUDIO
    };
    string fill_chars = ".pngjewbifscrhotmau_ld 3m4gvwfACPNGLF";

    // Hand-picked prompts; only the two one-item prompts carry a typed answer
    probe_row_t probe_rows [21] = '{
        // empty prompt right after reset, tools requested
        '{8'h00, 1'b1, 1'b1, 1'b1, {1'b1, 1'b0, 1'b0, 1'b0, 19'd0}},
        // single non-ASCII byte, no tools
        '{8'hFF, 1'b1, 1'b0, 1'b1, {1'b0, 1'b0, 1'b0, 1'b0, 19'd0}},
        // mixed-case image marker ending on the last item
        '{".", 1'b0, 1'b0, 1'b0, '0},
        '{"P", 1'b0, 1'b1, 1'b0, '0},
        '{"n", 1'b0, 1'b0, 1'b0, '0},
        '{"G", 1'b1, 1'b1, 1'b0, '0},
        // spaced pdf marker, terminator, then an audio marker that is ignored
        '{" ", 1'b0, 1'b1, 1'b0, '0},
        '{"p", 1'b0, 1'b0, 1'b0, '0},
        '{"D", 1'b0, 1'b0, 1'b0, '0},
        '{"F", 1'b0, 1'b0, 1'b0, '0},
        '{" ", 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{".", 1'b0, 1'b1, 1'b0, '0},
        '{"w", 1'b0, 1'b0, 1'b0, '0},
        '{"A", 1'b0, 1'b0, 1'b0, '0},
        '{"V", 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, 1'b0, '0},
        // audio marker on a prompt without terminator
        '{".", 1'b0, 1'b0, 1'b0, '0},
        '{"m", 1'b0, 1'b0, 1'b0, '0},
        '{"4", 1'b0, 1'b0, 1'b0, '0},
        '{"A", 1'b1, 1'b1, 1'b0, '0}
    };

    keyword_capability_scanner_unit #(
        .MAX_PROMPT_BYTES(TB_MAX_BYTES)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void clear_scan_state();
        for (int i = 0; i < 9; i++) begin
            hist_bytes[i] = 8'h00;
        end
        group_hits = '0;
        text_len   = 0;
        text_done  = 1'b0;
    endfunction

    // Compare a marker against the newest end of the window
    function automatic bit marker_at_tail(input logic [7:0] win [10], input string mk);
        int n;
        n = mk.len();
        for (int k = 0; k < n; k++) begin
            if (win[k] != mk[n - 1 - k]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Advance the scan by one item; return 1 and the capabilities on a last item
    function automatic bit predict_capabilities(input kcs_in_t it, output kcs_out_t caps);
        logic [7:0]  c;
        logic [7:0]  win [10];
        int unsigned est;
        caps = '0;
        if (!text_done) begin
            if (it.text_byte == CHAR_NUL) begin
                text_done = 1'b1;
            end else begin
                c = it.text_byte;
                if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
                    c = c + CASE_OFFSET;
                end
                win[0] = c;
                for (int i = 0; i < 9; i++) begin
                    win[i + 1] = hist_bytes[i];
                end
                for (int m = 0; m < MARKER_COUNT; m++) begin
                    if (marker_at_tail(win, marker_text[m])) begin
                        group_hits[marker_grp[m]] = 1'b1;
                    end
                end
                for (int i = 8; i > 0; i--) begin
                    hist_bytes[i] = hist_bytes[i - 1];
                end
                hist_bytes[0] = c;
                if (text_len < TB_MAX_BYTES) begin
                    text_len++;
                end
            end
        end
        if (!it.last_byte) begin
            return 1'b0;
        end
        est = text_len / 4 + 1;
        caps.need_tools  = it.tools_allowed;
        caps.need_vision = group_hits[GRP_IMAGE];
        caps.need_pdf    = group_hits[GRP_PDF];
        caps.need_audio  = group_hits[GRP_AUDIO];
        caps.ctx_tokens  = (est > EST_LIMIT) ? CTX_W'(est + CTX_BIAS) : '0;
        clear_scan_state();
        return 1'b1;
    endfunction

    // Append text, optionally in random case and with one byte corrupted
    function automatic void push_text(input string s, input bit mix_case, input int bad_at);
        logic [7:0] ch;
        for (int k = 0; k < s.len(); k++) begin
            ch = s[k];
            if (mix_case && ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1) begin
                ch = ch - CASE_OFFSET;
            end
            if (k == bad_at) begin
                ch = 8'($urandom_range(1, 255));
            end
            prompt_q.push_back(ch);
        end
    endfunction

    // Build one random prompt from markers, near misses, filler and tails
    function automatic void build_prompt();
        int    chunks;
        int    kind;
        string mk;
        if ($urandom_range(0, 19) == 0) begin
            prompt_q.push_back(CHAR_NUL);
            return;
        end
        chunks = $urandom_range(1, 5);
        repeat (chunks) begin
            kind = $urandom_range(0, 9);
            if (kind <= 4) begin
                mk = marker_text[$urandom_range(0, MARKER_COUNT - 1)];
                push_text(mk, 1'b1, (kind == 4) ? $urandom_range(0, mk.len() - 1) : -1);
            end else if (kind <= 6) begin
                repeat ($urandom_range(1, 8)) begin
                    prompt_q.push_back(fill_chars[$urandom_range(0, fill_chars.len() - 1)]);
                end
            end else if (kind == 7) begin
                repeat ($urandom_range(1, 6)) begin
                    prompt_q.push_back(8'($urandom_range(1, 255)));
                end
            end else if (kind == 8) begin
                repeat ($urandom_range(1, 4)) begin
                    prompt_q.push_back(8'($urandom_range(0, 255)));
                end
            end else begin
                // terminator followed by bytes the block must ignore
                prompt_q.push_back(CHAR_NUL);
                repeat ($urandom_range(1, 6)) begin
                    prompt_q.push_back(8'($urandom_range(0, 255)));
                end
                push_text(marker_text[$urandom_range(0, MARKER_COUNT - 1)], 1'b0, -1);
            end
        end
        if ($urandom_range(0, 2) == 0) begin
            prompt_q.push_back(CHAR_NUL);
        end
    endfunction

    // Offer one item, wait for acceptance, then record what it should cause
    task automatic send_item(input kcs_in_t it, input bit typed, input kcs_out_t want);
        kcs_out_t caps;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (!text_done) begin
            scan_items++;
        end
        if (predict_capabilities(it, caps)) begin
            expected_caps_q.push_back(typed ? want : caps);
        end
    endtask

    task automatic send_prompt();
        kcs_in_t it;
        for (int i = 0; i < prompt_q.size(); i++) begin
            it.text_byte     = prompt_q[i];
            it.last_byte     = (i == prompt_q.size() - 1);
            it.tools_allowed = 1'($urandom_range(0, 1));
            send_item(it, 1'b0, '0);
        end
        prompt_q.delete();
    endtask

    function automatic void note_mismatch(input kcs_out_t want, input kcs_out_t got,
                                          input bit orphan);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            if (orphan) begin
                $write("result %0d arrived with nothing expected:", result_count);
                $display(" tools=%0b vision=%0b pdf=%0b audio=%0b ctx=%0d",
                         got.need_tools, got.need_vision, got.need_pdf, got.need_audio,
                         got.ctx_tokens);
            end else begin
                $write("result %0d mismatch: expected tools=%0b vision=%0b pdf=%0b ",
                       result_count, want.need_tools, want.need_vision, want.need_pdf);
                $write("audio=%0b ctx=%0d,", want.need_audio, want.ctx_tokens);
                $display(" got tools=%0b vision=%0b pdf=%0b audio=%0b ctx=%0d",
                         got.need_tools, got.need_vision, got.need_pdf, got.need_audio,
                         got.ctx_tokens);
            end
        end
    endfunction

    // Check each accepted result against the oldest expectation
    always @(posedge aclk) begin : result_check
        kcs_out_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (expected_caps_q.size() == 0) begin
                note_mismatch('0, m_data, 1'b1);
            end else begin
                want = expected_caps_q.pop_front();
                if (m_data.need_tools !== want.need_tools
                        || m_data.need_vision !== want.need_vision
                        || m_data.need_pdf !== want.need_pdf
                        || m_data.need_audio !== want.need_audio
                        || m_data.ctx_tokens !== want.ctx_tokens) begin
                    note_mismatch(want, m_data, 1'b0);
                end
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        bit held;
        held    = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin : stimulus
        kcs_in_t it;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        hold_request   = 1'b0;
        send_idle_pct  = 6;
        recv_idle_pct  = 76;
        mismatch_count = 0;
        result_count   = 0;
        scan_items     = 0;
        clear_scan_state();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the hand-picked prompts
        foreach (probe_rows[i]) begin
            it.text_byte     = probe_rows[i].ch;
            it.last_byte     = probe_rows[i].last;
            it.tools_allowed = probe_rows[i].tools;
            send_item(it, probe_rows[i].typed, probe_rows[i].want);
        end

        // Random prompts under three idling mixes
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 76 : 0;
            recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 6 : 0;
            if (phase == 2) begin
                hold_request = 1'b1;
            end
            scan_items = 0;
            while (scan_items < PHASE_ITEMS) begin
                build_prompt();
                send_prompt();
            end
        end

        s_valid <= 1'b0;
        while (expected_caps_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/kcs_pkg.sv
rtl/keyword_capability_scanner_unit.sv
rtl/kcs_checker.sv
tb/sv/tb_keyword_capability_scanner_unit.sv
